@@ rtl/wrs_pkg.sv @@
// Shared types and constants for the weighted random selector.
// No dependencies; imported by the divider and the top level.
package wrs_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 64;
   localparam int RND_W               = 31;
   localparam int IDX_W               = 6;
   localparam int WEIGHT_W            = 2;
   localparam int COUNT_W             = 7;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   localparam logic [WEIGHT_W-1:0] WEIGHT_DEFAULT = 2'd1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_NONE    = 2'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_SUM_END,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FIND,
      ST_FIND_END,
      ST_RDW,
      ST_RDW_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ rtl/wrs_div.sv @@
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on wrs_pkg for the status struct.
module wrs_div #(
   parameter int DW = 31,
   parameter int SW = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DW-1:0]         dividend,
   input  logic [SW-1:0]         divisor,
   output logic [SW-1:0]         remainder,
   output wrs_pkg::div_stat_type stat
);
   import wrs_pkg::*;

   localparam int CNW = $clog2(DW + 1);

   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [DW-1:0]  quo_ff, quo_in;
   logic [SW-1:0]  dvs_ff, dvs_in;
   logic [SW-1:0]  rem_ff, rem_in;
   logic [SW:0]    step;
   logic [SW:0]    diff;
   logic           ge;

   // shift in the next dividend bit and subtract when it fits
   assign step = {rem_ff, quo_ff[DW-1]};
   assign ge   = step >= {1'b0, dvs_ff};
   assign diff = step - {1'b0, dvs_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         cnt_in  = CNW'(DW);
         busy_in = 1'b1;
         quo_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[SW-1:0] : step[SW-1:0];
         quo_in = {quo_ff[DW-2:0], 1'b0};
         cnt_in = cnt_ff - CNW'(1);
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign remainder = rem_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ rtl/weighted_random_selector_no_repeat_core.sv @@
// Roulette-wheel selector without immediate repeat; top level.
// Depends on wrs_pkg and wrs_div (remainder unit).
// A write, an ignored event or the first of a pair is answered in the next cycle; a pick
//   makes up to two scans of the weight memory through its one read port, plus the
//   bit-serial remainder.
// Throughput: one request at a time; the next is taken once the current one is done.
// Reset: synchronous, clears parity, last pick, entry count and handshake state.
module weighted_random_selector_no_repeat_core #(
   parameter int MAX_ENTRIES = wrs_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [wrs_pkg::IDX_W-1:0]     req_entry_index,
   input  logic [2:0]                    req_entry_weight,
   input  logic                          req_is_standard,
   input  logic [wrs_pkg::RND_W-1:0]     req_random_value,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_picked,
   output logic [wrs_pkg::IDX_W-1:0]     rsp_picked_index,
   output logic [wrs_pkg::WEIGHT_W-1:0]  rsp_picked_weight,
   // configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wrs_pkg::COUNT_W-1:0]   csr_entry_count
);
   import wrs_pkg::*;

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int SW = $clog2(3 * MAX_ENTRIES + 1);

   // weight memory: one write port, one registered read port
   logic [WEIGHT_W-1:0] mem [MAX_ENTRIES];
   logic                mem_we;
   logic [IW-1:0]       mem_waddr;
   logic [WEIGHT_W-1:0] mem_wdata;
   logic                mem_re;
   logic [IW-1:0]       mem_raddr;

   logic [WEIGHT_W-1:0] rd_data_ff;
   logic                rd_vld_ff;
   logic [IW-1:0]       rd_idx_ff;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0]  entry_count_ff, entry_count_in;
   logic                parity_ff, parity_in;
   logic                last_vld_ff, last_vld_in;
   logic [IW-1:0]       last_idx_ff, last_idx_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [RND_W-1:0]    rnd_ff, rnd_in;
   logic [IW-1:0]       addr_ff, addr_in;
   logic [SW-1:0]       sum_ff, sum_in;
   logic [SW-1:0]       acc_ff, acc_in;
   logic [SW-1:0]       r_ff, r_in;
   logic [IW-1:0]       sel_ff, sel_in;
   logic [WEIGHT_W-1:0] wsel_ff, wsel_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_picked_ff, rsp_picked_in;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [WEIGHT_W-1:0] rsp_weight_ff, rsp_weight_in;

   logic                req_acc;
   logic                csr_acc;
   logic                ev_count;
   logic                ev_pick;
   logic [CW-1:0]       cnt_lim;
   logic [IW-1:0]       cnt_m1;
   logic                excluded;
   logic [SW-1:0]       add_w;
   logic [SW-1:0]       acc_new;
   logic                hit;
   logic                sum_zero;

   logic                div_start;
   logic [SW-1:0]       div_divisor;
   logic [SW-1:0]       div_rem;
   div_stat_type        div_stat;

   // ------------------------------------------------------------------
   // Handshakes: take a request only when idle and the result slot is
   // free or drains this cycle; a pick fills the slot only at its end.
   // ------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = (state_ff == ST_IDLE);
   assign csr_acc   = csr_valid && csr_ready;

   // clamp the configured count to the table size
   assign cnt_lim = (32'(entry_count_ff) < 32'(MAX_ENTRIES)) ? CW'(entry_count_ff)
                                                              : CW'(MAX_ENTRIES);
   assign cnt_m1  = IW'(cnt_ff - CW'(1));

   // a standard event flips the parity; the second of a pair picks
   assign ev_count = req_acc && (req_op == OP_EVENT) && req_is_standard;
   assign ev_pick  = ev_count && parity_ff && (cnt_lim != '0);

   // running-sum contribution of the entry arriving from memory this cycle,
   // with the last pick dropped from the wheel
   assign excluded = last_vld_ff && (rd_idx_ff == last_idx_ff);
   assign add_w    = (rd_vld_ff && !excluded) ? SW'(rd_data_ff) : '0;
   assign acc_new  = acc_ff + add_w;
   assign hit      = rd_vld_ff && (r_ff < acc_new);
   assign sum_zero = (sum_ff == '0);

   // zero weight sum falls back to a plain modulo of the count
   assign div_divisor = sum_zero ? SW'(cnt_ff) : sum_ff;

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ev_pick) begin
               state_in = (cnt_lim == CW'(1)) ? ST_RDW : ST_SUM;
            end
         end
         ST_SUM: begin
            if (addr_ff == cnt_m1) state_in = ST_SUM_END;
         end
         ST_SUM_END:   state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_stat.done && !div_stat.busy) begin
               state_in = sum_zero ? ST_RDW : ST_FIND;
            end
         end
         ST_FIND: begin
            if (hit) begin
               state_in = ST_OUT;
            end else if (addr_ff == cnt_m1) begin
               state_in = ST_FIND_END;
            end
         end
         ST_FIND_END: state_in = ST_OUT;
         ST_RDW:      state_in = ST_RDW_WAIT;
         ST_RDW_WAIT: state_in = ST_OUT;
         ST_OUT:      state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Control outputs: memory read port and remainder unit start
   // ------------------------------------------------------------------
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = addr_ff;
      div_start = 1'b0;
      case (state_ff)
         ST_SUM, ST_FIND: mem_re = 1'b1;
         ST_RDW: begin
            mem_re    = 1'b1;
            mem_raddr = sel_ff;
         end
         ST_DIV_START: div_start = 1'b1;
         default: begin
            mem_re    = 1'b0;
            div_start = 1'b0;
         end
      endcase
   end

   // writes land only while idle and reads only during a pick, so the
   // port never sees a read and a write of the same entry overlap
   always_comb begin
      mem_we    = req_acc && (req_op == OP_WRITE) &&
                  (32'(req_entry_index) < 32'(MAX_ENTRIES));
      mem_waddr = IW'(req_entry_index);
      mem_wdata = (req_entry_weight inside {[3'd1:3'd3]}) ? WEIGHT_W'(req_entry_weight)
                                                          : WEIGHT_DEFAULT;
   end

   // ------------------------------------------------------------------
   // Datapath next values
   // ------------------------------------------------------------------
   always_comb begin
      entry_count_in = entry_count_ff;
      parity_in      = parity_ff;
      last_vld_in    = last_vld_ff;
      last_idx_in    = last_idx_ff;
      cnt_in         = cnt_ff;
      rnd_in         = rnd_ff;
      addr_in        = addr_ff;
      sum_in         = sum_ff;
      acc_in         = acc_ff;
      r_in           = r_ff;
      sel_in         = sel_ff;
      wsel_in        = wsel_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_picked_in  = rsp_picked_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_weight_in  = rsp_weight_ff;

      if (csr_acc) entry_count_in = csr_entry_count;

      case (state_ff)
         ST_IDLE: begin
            if (ev_count) parity_in = ~parity_ff;
            if (ev_pick) begin
               // hold the operands for the whole pick
               cnt_in  = cnt_lim;
               rnd_in  = req_random_value;
               addr_in = '0;
               sum_in  = '0;
               sel_in  = '0;
            end else if (req_acc) begin
               // writes and non-picking events answer at once
               rsp_valid_in  = 1'b1;
               rsp_picked_in = 1'b0;
               rsp_index_in  = '0;
               rsp_weight_in = WEIGHT_NONE;
            end
         end
         ST_SUM: begin
            addr_in = addr_ff + IW'(1);
            sum_in  = sum_ff + add_w;
         end
         ST_SUM_END: sum_in = sum_ff + add_w;
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               r_in    = div_rem;
               sel_in  = IW'(div_rem);
               addr_in = '0;
               acc_in  = '0;
            end
         end
         ST_FIND: begin
            addr_in = addr_ff + IW'(1);
            acc_in  = acc_new;
            if (hit) begin
               sel_in  = rd_idx_ff;
               wsel_in = rd_data_ff;
            end
         end
         ST_FIND_END: begin
            if (hit) begin
               sel_in  = rd_idx_ff;
               wsel_in = rd_data_ff;
            end else begin
               sel_in  = '0;
               wsel_in = WEIGHT_NONE;
            end
         end
         ST_RDW_WAIT: wsel_in = rd_data_ff;
         ST_OUT: begin
            rsp_valid_in  = 1'b1;
            rsp_picked_in = 1'b1;
            rsp_index_in  = IDX_W'(sel_ff);
            rsp_weight_in = wsel_ff;
            last_vld_in   = 1'b1;
            last_idx_in   = sel_ff;
         end
         default: begin
            sum_in = sum_ff;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         parity_ff      <= 1'b0;
         last_vld_ff    <= 1'b0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         parity_ff      <= parity_in;
         last_vld_ff    <= last_vld_in;
         rd_vld_ff      <= mem_re;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rd_idx_ff     <= mem_raddr;
      last_idx_ff   <= last_idx_in;
      cnt_ff        <= cnt_in;
      rnd_ff        <= rnd_in;
      addr_ff       <= addr_in;
      sum_ff        <= sum_in;
      acc_ff        <= acc_in;
      r_ff          <= r_in;
      sel_ff        <= sel_in;
      wsel_ff       <= wsel_in;
      rsp_picked_ff <= rsp_picked_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_weight_ff <= rsp_weight_in;
   end

   // random value modulo the wheel size
   wrs_div #(
      .DW (RND_W),
      .SW (SW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rnd_ff),
      .divisor   (div_divisor),
      .remainder (div_rem),
      .stat      (div_stat)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_picked        = rsp_picked_ff;
   assign rsp_picked_index  = rsp_index_ff;
   assign rsp_picked_weight = rsp_weight_ff;

endmodule
